>>> hw/rtl/bloom_filter_engine_top_macros.svh
// Assertion macros shared by the checker of the Bloom filter engine.
`ifndef BLOOM_FILTER_ENGINE_TOP_MACROS_SVH
`define BLOOM_FILTER_ENGINE_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define BFE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bloom filter engine check failed");

// Checked at every edge, reset included.
`define BFE_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bloom filter engine check failed");

`endif

>>> hw/rtl/bfe_pkg.sv
// Package of the Bloom filter engine: item types, action codes, hash constants and states.
`default_nettype none

package bfe_pkg;

	// Action codes of an input item.
	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Multipliers of the two hashes.
	localparam logic [63:0] HASH_MUL_A = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] HASH_MUL_B = 64'hC96C5795D7870F42;

	// Width of one memory row and of the bit offset inside it.
	localparam int unsigned ROW_W  = 32;
	localparam int unsigned BIT_AW = 5;

	// Field widths of a result item and the percent scale.
	localparam int unsigned OUT_CNT_W = 17;
	localparam int unsigned PCT_W     = 7;
	localparam int unsigned SAT_SCALE = 100;

	// Entries of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = 1;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
	} cmd_t;

	typedef struct packed {
		logic                 maybe_present;
		logic [OUT_CNT_W-1:0] ones_count;
		logic                 needs_rebuild;
		logic [PCT_W-1:0]     saturation_percent;
	} res_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_HASH,
		BK_CLEAR,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bfe_stream_if.sv
// Valid/ready channel interface that carries one item per handshake.
`default_nettype none

interface bfe_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bloom_filter_engine_top.sv
// Top level of the Bloom filter engine: front part, work queue and back part.
`default_nettype none

// Bloom filter over 64-bit keys with double hashing. Each cmd item carries an
// action (add, query or clear) and a key; each one gives exactly one res item
// with the query answer, the ones count, the rebuild flag and the saturation
// percent as they stand after the action. FILTER_BITS must be a power of two.
// The front part takes an item, forms both hashes on the low index bits of the
// key and places the work in a two-entry queue, so a new item is taken while
// the back part is still busy and while a result waits on res. The back part
// visits the bit indices one per cycle through a 32-bit-wide filter memory
// with one write and one registered read port, forwarding a row just written
// to the next read. An add or a query walks its HASH_COUNT indices, a clear zeroes
// the FILTER_BITS / 32 rows of the memory one row per cycle, and the unused action
// code goes straight to its result. After reset the same clearing pass runs, during
// which no item is taken.
module bloom_filter_engine_top #(
	parameter int unsigned FILTER_BITS = 65536,
	parameter int unsigned HASH_COUNT  = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bfe_stream_if.sink   cmd,
	bfe_stream_if.source res
);

	localparam int unsigned IDX_W = $clog2(FILTER_BITS);
	localparam int unsigned QW    = 2 * IDX_W + 2;

	logic          push_valid;
	logic          push_ready;
	logic [QW-1:0] push_data;
	logic          pop_valid;
	logic          pop_ready;
	logic [QW-1:0] pop_data;
	logic          init_busy;

	// Hashing and intake.
	bfe_front #(
		.IDX_W (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.hold       (init_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Work waiting for the back part.
	bfe_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Filter memory, counting and the result register.
	bfe_back #(
		.FILTER_BITS (FILTER_BITS),
		.HASH_COUNT  (HASH_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res       (res),
		.init_busy (init_busy)
	);

endmodule

`default_nettype wire

>>> hw/rtl/bfe_front.sv
// Front part: accepts items, hashes the key and hands the work to the queue.
`default_nettype none

module bfe_front #(
	parameter int unsigned IDX_W = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	bfe_stream_if.sink                  cmd,
	input  wire logic                   hold,
	output logic                        push_valid,
	input  wire logic                   push_ready,
	output logic [2*IDX_W+1:0]          push_data
);

	// Only the low index bits of each product ever reach the filter.
	localparam logic [IDX_W-1:0] MUL_A_LO = bfe_pkg::HASH_MUL_A[IDX_W-1:0];
	localparam logic [IDX_W-1:0] MUL_B_LO = bfe_pkg::HASH_MUL_B[IDX_W-1:0];

	logic             valid_s1;
	logic [1:0]       action_s1;
	logic [IDX_W-1:0] h1_s1;
	logic [IDX_W-1:0] h2_s1;
	logic             accept;

	assign cmd.ready  = !hold && (!valid_s1 || push_ready);
	assign accept     = cmd.valid && cmd.ready;
	assign push_valid = valid_s1;
	assign push_data  = {action_s1, h1_s1, h2_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= cmd.payload.action;
			h1_s1     <= cmd.payload.key[IDX_W-1:0] * MUL_A_LO;
			h2_s1     <= cmd.payload.key[IDX_W-1:0] * MUL_B_LO;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bfe_queue.sv
// Short queue that decouples the front part from the back part.
`default_nettype none

module bfe_queue #(
	parameter int unsigned WIDTH = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0]              entry_q [bfe_pkg::QUEUE_DEPTH];
	logic [bfe_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [bfe_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [bfe_pkg::QUEUE_AW:0]    fill_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = fill_q != (bfe_pkg::QUEUE_AW + 1)'(bfe_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/bfe_back.sv
// Back part: walks the hashed bit indices through the filter memory and reports status.
`default_nettype none

module bfe_back #(
	parameter int unsigned FILTER_BITS = 65536,
	parameter int unsigned HASH_COUNT  = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pop_valid,
	output logic                                   pop_ready,
	input  wire logic [2*$clog2(FILTER_BITS)+1:0]  pop_data,
	bfe_stream_if.source                           res,
	output logic                                   init_busy
);

	localparam int unsigned IDX_W  = $clog2(FILTER_BITS);
	localparam int unsigned CNT_W  = IDX_W + 1;
	localparam int unsigned ROWS   = FILTER_BITS / bfe_pkg::ROW_W;
	localparam int unsigned ROW_AW = $clog2(ROWS);
	localparam int unsigned HC_W   = $clog2(HASH_COUNT + 1);
	localparam int unsigned PROD_W = CNT_W + bfe_pkg::PCT_W + 1;

	localparam logic [HC_W-1:0]   HC_LAST  = HC_W'(HASH_COUNT);
	localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
	localparam logic [CNT_W-1:0]  HALF     = CNT_W'(FILTER_BITS / 2);

	bfe_pkg::back_state_t state_q, state_d;

	logic [bfe_pkg::ROW_W-1:0]  filter_mem_q [ROWS];
	logic [bfe_pkg::ROW_W-1:0]  mem_rdata_s1;

	logic [1:0]                 pop_action;
	logic [IDX_W-1:0]           pop_h1;
	logic [IDX_W-1:0]           pop_h2;

	logic [IDX_W-1:0]           acc_q;
	logic [IDX_W-1:0]           h2_q;
	logic [HC_W-1:0]            issue_q;
	logic                       is_add_q;
	logic                       all_q;
	logic [ROW_AW-1:0]          row_q;
	logic [CNT_W-1:0]           count_q;

	logic                       rd_v_s1;
	logic [ROW_AW-1:0]          rd_row_s1;
	logic [bfe_pkg::BIT_AW-1:0] rd_bit_s1;

	logic                       byp_v_q;
	logic [ROW_AW-1:0]          byp_row_q;
	logic [bfe_pkg::ROW_W-1:0]  byp_data_q;

	logic                       out_v_q;
	bfe_pkg::res_t              out_q;

	logic                       do_pop;
	logic                       rd_issue;
	logic [ROW_AW-1:0]          mem_raddr;
	logic                       mem_we;
	logic [ROW_AW-1:0]          mem_waddr;
	logic [bfe_pkg::ROW_W-1:0]  mem_wdata;
	logic [bfe_pkg::ROW_W-1:0]  rd_word;
	logic                       hit;
	logic                       hash_done;
	logic                       sweep_last;
	logic                       load_out;
	logic                       sweeping;
	logic [PROD_W-1:0]          pct_prod;

	assign pop_action = pop_data[2*IDX_W +: 2];
	assign pop_h1     = pop_data[IDX_W +: IDX_W];
	assign pop_h2     = pop_data[0 +: IDX_W];

	// A row written in the previous cycle is newer than what the memory returned.
	assign rd_word = (byp_v_q && (byp_row_q == rd_row_s1)) ? byp_data_q : mem_rdata_s1;
	assign hit     = rd_word[rd_bit_s1];

	assign sweep_last = row_q == ROW_LAST;
	assign hash_done  = (issue_q == HC_LAST) && !rd_v_s1;
	assign pct_prod   = PROD_W'(count_q) * PROD_W'(bfe_pkg::SAT_SCALE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfe_pkg::BK_INIT: begin
				if (sweep_last) begin
					state_d = bfe_pkg::BK_IDLE;
				end
			end
			bfe_pkg::BK_IDLE: begin
				if (pop_valid) begin
					if (pop_action == bfe_pkg::ACT_ADD || pop_action == bfe_pkg::ACT_QUERY) begin
						state_d = bfe_pkg::BK_HASH;
					end else if (pop_action == bfe_pkg::ACT_CLEAR) begin
						state_d = bfe_pkg::BK_CLEAR;
					end else begin
						state_d = bfe_pkg::BK_DONE;
					end
				end
			end
			bfe_pkg::BK_HASH: begin
				if (hash_done) begin
					state_d = bfe_pkg::BK_DONE;
				end
			end
			bfe_pkg::BK_CLEAR: begin
				if (sweep_last) begin
					state_d = bfe_pkg::BK_DONE;
				end
			end
			bfe_pkg::BK_DONE: begin
				if (!out_v_q || res.ready) begin
					state_d = bfe_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = bfe_pkg::BK_INIT;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop_ready = 1'b0;
		rd_issue  = 1'b0;
		sweeping  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = rd_row_s1;
		mem_wdata = rd_word | (bfe_pkg::ROW_W'(1) << rd_bit_s1);
		load_out  = 1'b0;
		mem_raddr = acc_q[IDX_W-1:bfe_pkg::BIT_AW];
		unique case (state_q)
			bfe_pkg::BK_INIT, bfe_pkg::BK_CLEAR: begin
				sweeping  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = row_q;
				mem_wdata = '0;
			end
			bfe_pkg::BK_IDLE: begin
				pop_ready = 1'b1;
			end
			bfe_pkg::BK_HASH: begin
				rd_issue = issue_q != HC_LAST;
				mem_we   = rd_v_s1 && is_add_q && !hit;
			end
			bfe_pkg::BK_DONE: begin
				load_out = !out_v_q || res.ready;
			end
			default: begin
				pop_ready = 1'b0;
			end
		endcase
	end

	assign do_pop    = pop_valid && pop_ready;
	assign init_busy = state_q == bfe_pkg::BK_INIT;

	assign res.valid   = out_v_q;
	assign res.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfe_pkg::BK_INIT;
			row_q   <= '0;
			count_q <= '0;
			issue_q <= '0;
			rd_v_s1 <= 1'b0;
			byp_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_issue;
			byp_v_q <= mem_we;
			if (sweeping) begin
				row_q <= row_q + 1'b1;
			end
			if (do_pop) begin
				row_q   <= '0;
				issue_q <= '0;
				if (pop_action == bfe_pkg::ACT_CLEAR) begin
					count_q <= '0;
				end
			end else if (rd_issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (mem_we && !sweeping) begin
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			acc_q    <= pop_h1;
			h2_q     <= pop_h2;
			is_add_q <= pop_action == bfe_pkg::ACT_ADD;
			all_q    <= pop_action == bfe_pkg::ACT_QUERY;
		end else begin
			if (rd_issue) begin
				acc_q <= acc_q + h2_q;
			end
			if (rd_v_s1 && !is_add_q) begin
				all_q <= all_q & hit;
			end
		end
		rd_row_s1  <= mem_raddr;
		rd_bit_s1  <= acc_q[bfe_pkg::BIT_AW-1:0];
		byp_row_q  <= mem_waddr;
		byp_data_q <= mem_wdata;
		if (load_out) begin
			out_q.maybe_present      <= all_q;
			out_q.ones_count         <= bfe_pkg::OUT_CNT_W'(count_q);
			out_q.needs_rebuild      <= count_q > HALF;
			out_q.saturation_percent <= pct_prod[IDX_W +: bfe_pkg::PCT_W];
		end
	end

	// Filter storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			filter_mem_q[mem_waddr] <= mem_wdata;
		end
		mem_rdata_s1 <= filter_mem_q[mem_raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/bfe_checker.sv
// Port-level checks of the Bloom filter engine and their attachment to the top level.
`default_nettype none

`include "bloom_filter_engine_top_macros.svh"

module bfe_checker #(
	parameter int unsigned FILTER_BITS = 65536
) (
	input wire logic     clk,
	input wire logic     arst_n,
	bfe_stream_if.sink   cmd,
	bfe_stream_if.source res
);

	localparam bit NARROW = FILTER_BITS <= 65536;

	// No item may be taken while reset is applied.
	`BFE_ASSERT_ALWAYS(a_no_cmd_in_reset, clk, !arst_n |-> !cmd.ready)

	// No result may appear while reset is applied.
	`BFE_ASSERT_ALWAYS(a_no_res_in_reset, clk, !arst_n |-> !res.valid)

	// A positive query needs set bits somewhere in the filter.
	`BFE_ASSERT(a_hit_needs_ones, clk, arst_n, (res.valid && res.payload.maybe_present && NARROW) |-> (res.payload.ones_count != '0))

	// Saturation never passes the full scale.
	`BFE_ASSERT(a_pct_range, clk, arst_n, res.valid |-> (res.payload.saturation_percent <= 7'd100))

	// A result that is not taken stays as it is.
	`BFE_ASSERT(a_res_hold, clk, arst_n, (res.valid && !res.ready) |=> (res.valid && $stable(res.payload)))

endmodule

bind bloom_filter_engine_top bfe_checker #(
	.FILTER_BITS (FILTER_BITS)
) u_bfe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.res    (res)
);

`default_nettype wire

>>> bench/bfe_result_checker.sv
// Result checker of the Bloom filter engine: predicts each result item and compares it.
`timescale 1ns / 1ps

module bfe_result_checker
	import bfe_pkg::*;
#(
	parameter int unsigned FILTER_BITS = 65536,
	parameter int unsigned HASH_COUNT  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  cmd_t        cmd_payload,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_t        res_payload,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned result_count,
	output int unsigned hit_count,
	output int unsigned peak_ones,
	output logic        rebuild_seen
);

	// Own copy of the filter and of its population count.
	bit          filter_map [FILTER_BITS];
	int unsigned set_total = 0;

	res_t        status_q [$];
	int unsigned mismatches = 0;
	int unsigned checked    = 0;
	int unsigned hits       = 0;
	int unsigned peak       = 0;
	logic        rebuilt    = 1'b0;

	assign fail_count   = mismatches;
	assign pending      = status_q.size();
	assign result_count = checked;
	assign hit_count    = hits;
	assign peak_ones    = peak;
	assign rebuild_seen = rebuilt;

	// Applies one item to the filter copy and returns the status it should report.
	function automatic res_t apply_action(input cmd_t item);
		logic [63:0] h1;
		logic [63:0] h2;
		logic [63:0] pos;
		logic [63:0] i;
		logic        all_set;
		res_t        status;
		h1      = item.key * HASH_MUL_A;
		h2      = item.key * HASH_MUL_B;
		all_set = 1'b1;
		case (item.action)
			ACT_ADD: begin
				for (i = 0; i < HASH_COUNT; i++) begin
					pos = (h1 + i * h2) & 64'(FILTER_BITS - 1);
					if (!filter_map[pos]) begin
						filter_map[pos] = 1'b1;
						set_total++;
					end
				end
			end
			ACT_QUERY: begin
				for (i = 0; i < HASH_COUNT; i++) begin
					pos = (h1 + i * h2) & 64'(FILTER_BITS - 1);
					if (!filter_map[pos])
						all_set = 1'b0;
				end
			end
			ACT_CLEAR: begin
				foreach (filter_map[j])
					filter_map[j] = 1'b0;
				set_total = 0;
			end
			default: ;
		endcase
		status.maybe_present      = (item.action == ACT_QUERY) ? all_set : 1'b0;
		status.ones_count         = OUT_CNT_W'(set_total);
		status.needs_rebuild      = (set_total > FILTER_BITS / 2);
		status.saturation_percent = PCT_W'((64'(set_total) * SAT_SCALE) / FILTER_BITS);
		if (set_total > peak)
			peak = set_total;
		return status;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// Results are taken before new items so that a result never meets its own item.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (status_q.size() == 0) begin
					$error("result item arrived with no item outstanding");
					mismatches++;
				end else begin
					want = status_q.pop_front();
					check_field("maybe_present", 32'(want.maybe_present),
						32'(res_payload.maybe_present));
					check_field("ones_count", 32'(want.ones_count),
						32'(res_payload.ones_count));
					check_field("needs_rebuild", 32'(want.needs_rebuild),
						32'(res_payload.needs_rebuild));
					check_field("saturation_percent", 32'(want.saturation_percent),
						32'(res_payload.saturation_percent));
					checked++;
					if (want.maybe_present)
						hits++;
					if (want.needs_rebuild)
						rebuilt = 1'b1;
				end
			end
			if (cmd_valid && cmd_ready)
				status_q.push_back(apply_action(cmd_payload));
		end
	end

endmodule

>>> bench/bloom_filter_engine_top_test.sv
// Top of the Bloom filter engine testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module bloom_filter_engine_top_test;
	import bfe_pkg::*;

	localparam int unsigned FILTER_BITS = 65536;
	localparam int unsigned HASH_COUNT  = 4;

	// The package has no name for the spare action code, so it is given one here.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Random items per idling phase.
	localparam int unsigned PHASE_ITEMS = 330;

	logic clk;
	logic arst_n;

	bfe_stream_if #(.payload_t(cmd_t)) cmd_if ();
	bfe_stream_if #(.payload_t(res_t)) res_if ();

	// Chance, in percent, that the sender or the receiver idles in a given cycle.
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// Keys added since the last clear, so that queries can aim at them.
	logic [63:0] added_keys [$];

	int unsigned adds_sent    = 0;
	int unsigned queries_sent = 0;
	int unsigned clears_sent  = 0;
	int unsigned spares_sent  = 0;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned result_count;
	int unsigned hit_count;
	int unsigned peak_ones;
	logic        rebuild_seen;

	bloom_filter_engine_top #(
		.FILTER_BITS(FILTER_BITS),
		.HASH_COUNT (HASH_COUNT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.res   (res_if)
	);

	// The checker watches both channels from outside and keeps its own filter copy.
	bfe_result_checker #(
		.FILTER_BITS(FILTER_BITS),
		.HASH_COUNT (HASH_COUNT)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_if.valid),
		.cmd_ready   (cmd_if.ready),
		.cmd_payload (cmd_if.payload),
		.res_valid   (res_if.valid),
		.res_ready   (res_if.ready),
		.res_payload (res_if.payload),
		.fail_count  (fail_count),
		.pending     (pending),
		.result_count(result_count),
		.hit_count   (hit_count),
		.peak_ones   (peak_ones),
		.rebuild_seen(rebuild_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides afresh on every falling edge whether it will take a result.
	initial res_if.ready = 1'b0;

	always @(negedge clk) begin
		if (arst_n)
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offers one item and returns on the falling edge after it has been taken. Valid is
	// left high, so back-to-back items go out without a gap unless the sender idles.
	task automatic send_item(input logic [1:0] act, input logic [63:0] k);
		cmd_t item;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		item.action     = act;
		item.key        = k;
		cmd_if.valid   <= 1'b1;
		cmd_if.payload <= item;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		@(negedge clk);
		case (act)
			ACT_ADD: begin
				adds_sent++;
				added_keys.push_back(k);
				if (added_keys.size() > 256)
					void'(added_keys.pop_front());
			end
			ACT_QUERY: queries_sent++;
			ACT_CLEAR: begin
				clears_sent++;
				added_keys.delete();
			end
			default:   spares_sent++;
		endcase
	endtask

	// Keys of several shapes. Only the low index bits reach the hash products that
	// matter, so small keys and keys with only high bits set both probe corner cases.
	function automatic logic [63:0] fresh_key();
		case ($urandom_range(7))
			0:       return 64'($urandom_range(255));
			1:       return {$urandom, 32'h0};
			2:       return ~64'($urandom_range(65535));
			3:       return {$urandom, 16'h0, 16'($urandom_range(7) << 13)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One random item: mostly adds followed by queries of keys that are known to be in
	// the filter, with misses, repeated adds, rare clears and the spare code as noise.
	task automatic random_item();
		int unsigned pick;
		logic [63:0] k;
		pick = $urandom_range(99);
		if (pick < 45) begin
			send_item(ACT_ADD, fresh_key());
		end else if (pick < 85) begin
			if (added_keys.size() != 0 && $urandom_range(1))
				k = added_keys[$urandom_range(added_keys.size() - 1)];
			else
				k = fresh_key();
			send_item(ACT_QUERY, k);
		end else if (pick < 88) begin
			send_item(ACT_CLEAR, fresh_key());
		end else if (pick < 91) begin
			send_item(ACT_SPARE, fresh_key());
		end else if (added_keys.size() != 0) begin
			send_item(ACT_ADD, added_keys[$urandom_range(added_keys.size() - 1)]);
		end else begin
			send_item(ACT_ADD, fresh_key());
		end
	endtask

	initial begin
		int unsigned n;
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items. The block clears its memory after reset and holds off the first
		// item until then; the handshake takes care of that wait.
		send_item(ACT_QUERY, 64'h0);                    // empty filter
		send_item(ACT_ADD, 64'h0);                      // all indices fall on one bit
		send_item(ACT_QUERY, 64'h0);
		send_item(ACT_ADD, 64'h8000_0000_0000_0000);    // same single bit, nothing new
		send_item(ACT_ADD, 64'h0000_0000_0000_8000);    // second hash vanishes: one bit
		send_item(ACT_QUERY, 64'h0000_0000_0000_8000);
		send_item(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_QUERY, 64'hDEAD_BEEF_0000_FFFF);  // same low bits: a false hit
		send_item(ACT_QUERY, 64'h1234_5678_9ABC_DEF1);  // most likely a miss
		send_item(ACT_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);  // unused code changes nothing
		send_item(ACT_SPARE, 64'h0);
		send_item(ACT_ADD, 64'h1);
		send_item(ACT_ADD, 64'h5555_5555_AAAA_AAAA);
		send_item(ACT_QUERY, 64'h1);
		send_item(ACT_QUERY, 64'hAAAA_AAAA_5555_5555);
		send_item(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_QUERY, 64'h0);
		send_item(ACT_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_CLEAR, 64'h0);                    // clear of an empty filter
		send_item(ACT_ADD, 64'h0123_4567_89AB_CDEF);
		send_item(ACT_QUERY, 64'h0123_4567_89AB_CDEF);

		// Random items under three idling patterns, the last with no idling at all.
		send_idle_pct = 25;
		recv_idle_pct = 62;
		for (n = 0; n < PHASE_ITEMS; n++)
			random_item();
		send_idle_pct = 62;
		recv_idle_pct = 25;
		for (n = 0; n < PHASE_ITEMS; n++)
			random_item();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (n = 0; n < PHASE_ITEMS; n++)
			random_item();

		// Tail: a fresh filter, a few more random items, then a clear and a query of the
		// empty filter.
		send_item(ACT_CLEAR, 64'h0);
		for (n = 0; n < 40; n++)
			random_item();
		send_item(ACT_CLEAR, fresh_key());
		send_item(ACT_QUERY, 64'h0);
		cmd_if.valid <= 1'b0;

		// Drain: every item gives a result, so once nothing is outstanding only a short
		// settle is needed to catch a stray extra result.
		while (pending != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("Items sent: %0d adds, %0d queries, %0d clears, %0d with the spare code.",
			adds_sent, queries_sent, clears_sent, spares_sent);
		$display("Results checked: %0d, query hits %0d, peak ones count %0d, rebuild flag %s.",
			result_count, hit_count, peak_ones, rebuild_seen ? "raised" : "never raised");
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// A correct run spends most of its time in clearing passes, the pass after reset included;
	// this limit lies well beyond the slowest such run.
	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding.", pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
